// File: rtl/core/ntpodmf_pkg.sv
package ntpodmf_pkg;

   // long division of the 58-bit microsecond count (after the shift by 6) by 15625
   localparam int unsigned CHUNK_W    = 18;
   localparam int unsigned REM_W      = 14;
   localparam int unsigned REST_W     = REM_W + 1;
   localparam int unsigned DIVIDEND_W = REM_W + CHUNK_W;
   localparam int unsigned TOP_W      = 4;
   localparam int unsigned LOW_W      = 6;
   localparam int unsigned SECS_W     = 32;
   localparam int unsigned FRAC_W     = 32;
   localparam int unsigned US_REM_W   = REM_W + LOW_W;
   localparam int unsigned CHUNK_SHIFT = 45;
   localparam int unsigned FRAC_SHIFT  = 20;
   localparam int unsigned FRAC_PROD_W = US_REM_W + 33;
   localparam int unsigned RESID_W     = US_REM_W + 1;

   // stages from the input register to the fixed-point timestamp
   localparam int unsigned CONV_LAT = 8;

   localparam logic [REM_W-1:0] DIV_BASE    = 14'd15625;
   // floor(2^45 / 15625) and floor(2^52 / 10^6)
   localparam logic [31:0]      CHUNK_RECIP = 32'd2251799813;
   localparam logic [32:0]      FRAC_RECIP  = 33'd4503599627;

   localparam logic [19:0] US_PER_S      = 20'd1000000;
   localparam logic [9:0]  MS_PER_S      = 10'd1000;
   localparam logic [31:0] NTP_UNIX_SPAN = 32'd2208988800;
   localparam logic [63:0] SPAN_US       = 64'(NTP_UNIX_SPAN) * 64'(US_PER_S);

   typedef struct packed {
      logic valid;
      logic ok;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic        valid;
      logic        synced;
      logic [63:0] delay;
      logic [63:0] offset;
      logic [63:0] now;
   } record_type;

endpackage

// File: rtl/core/ntpodmf_chunk_div.sv
module ntpodmf_chunk_div (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [ntpodmf_pkg::REM_W-1:0]     rem_i,
   input  logic [ntpodmf_pkg::CHUNK_W-1:0]   chunk_i,
   output logic [ntpodmf_pkg::CHUNK_W-1:0]   quot_o,
   output logic [ntpodmf_pkg::REM_W-1:0]     rem_o
);
   import ntpodmf_pkg::*;

   logic [DIVIDEND_W-1:0]   num_in, num_ff;
   logic [2*DIVIDEND_W-1:0] prod_in, prod_ff;
   logic [CHUNK_W-1:0]      qest;
   logic [DIVIDEND_W-1:0]   back;
   logic [REST_W-1:0]       rest;
   logic [CHUNK_W-1:0]      quot_in, quot_ff;
   logic [REM_W-1:0]        rem_in, rem_ff;

   always_comb begin
      num_in  = {rem_i, chunk_i};
      prod_in = (2*DIVIDEND_W)'(num_in) * (2*DIVIDEND_W)'(CHUNK_RECIP);
   end

   // estimate is low by at most one
   always_comb begin
      qest = prod_ff[CHUNK_SHIFT +: CHUNK_W];
      back = DIVIDEND_W'(qest) * DIVIDEND_W'(DIV_BASE);
      rest = REST_W'(num_ff - back);
      if (rest >= REST_W'(DIV_BASE)) begin
         quot_in = qest + CHUNK_W'(1);
         rem_in  = REM_W'(rest - REST_W'(DIV_BASE));
      end else begin
         quot_in = qest;
         rem_in  = REM_W'(rest);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff  <= num_in;
         prod_ff <= prod_in;
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quot_o = quot_ff;
   assign rem_o  = rem_ff;

endmodule

// File: rtl/core/ntpodmf_us_to_fixed.sv
module ntpodmf_us_to_fixed (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] us_i,
   output logic [63:0] fixed_o
);
   import ntpodmf_pkg::*;

   logic [REM_W-1:0]       rem1, rem2, rem3;
   logic [CHUNK_W-1:0]     quot2, quot3;
   logic [CHUNK_W-1:0]     chunk2_ff [2];
   logic [CHUNK_W-1:0]     chunk3_ff [4];
   logic [LOW_W-1:0]       low_ff [6];
   logic [CHUNK_W-1:0]     quot2_ff [2];
   logic [US_REM_W-1:0]    frac_rem_in, frac_rem_ff;
   logic [FRAC_PROD_W-1:0] frac_prod_in, frac_prod_ff;
   logic [SECS_W-1:0]      secs_in, secs_ff;
   logic [FRAC_W-1:0]      fest, frac;
   logic [51:0]            back;
   logic [RESID_W-1:0]     resid;
   logic [63:0]            fixed_in, fixed_ff;

   // the top bits of us/64 are below the divisor and seed the remainder
   ntpodmf_chunk_div u_div1 (
      .clock   (clock),
      .enable  (enable),
      .rem_i   ({{(REM_W-TOP_W){1'b0}}, us_i[63:60]}),
      .chunk_i (us_i[59:42]),
      .quot_o  (),
      .rem_o   (rem1)
   );

   ntpodmf_chunk_div u_div2 (
      .clock   (clock),
      .enable  (enable),
      .rem_i   (rem1),
      .chunk_i (chunk2_ff[1]),
      .quot_o  (quot2),
      .rem_o   (rem2)
   );

   ntpodmf_chunk_div u_div3 (
      .clock   (clock),
      .enable  (enable),
      .rem_i   (rem2),
      .chunk_i (chunk3_ff[3]),
      .quot_o  (quot3),
      .rem_o   (rem3)
   );

   always_comb begin
      frac_rem_in  = {rem3, low_ff[5]};
      frac_prod_in = FRAC_PROD_W'(frac_rem_in) * FRAC_PROD_W'(FRAC_RECIP);
      secs_in      = {quot2_ff[1][SECS_W-CHUNK_W-1:0], quot3};
   end

   always_comb begin
      fest  = frac_prod_ff[FRAC_SHIFT +: FRAC_W];
      back  = 52'(fest) * 52'(US_PER_S);
      resid = RESID_W'({frac_rem_ff, 32'd0} - back);
      frac  = (resid >= RESID_W'(US_PER_S)) ? fest + FRAC_W'(1) : fest;
      fixed_in = {secs_ff, frac};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         chunk2_ff[0] <= us_i[41:24];
         chunk2_ff[1] <= chunk2_ff[0];
         chunk3_ff[0] <= us_i[23:6];
         for (int i = 1; i < 4; i++) chunk3_ff[i] <= chunk3_ff[i-1];
         low_ff[0] <= us_i[5:0];
         for (int i = 1; i < 6; i++) low_ff[i] <= low_ff[i-1];
         quot2_ff[0]  <= quot2;
         quot2_ff[1]  <= quot2_ff[0];
         frac_rem_ff  <= frac_rem_in;
         frac_prod_ff <= frac_prod_in;
         secs_ff      <= secs_in;
         fixed_ff     <= fixed_in;
      end
   end

   assign fixed_o = fixed_ff;

endmodule

// File: rtl/core/ntpodmf_min_filter.sv
module ntpodmf_min_filter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  ntpodmf_pkg::ctl_type    ctl_i,
   input  logic [63:0]             t1_i,
   input  logic [63:0]             t2_i,
   input  logic [63:0]             t3_i,
   input  logic [63:0]             t4_i,
   input  logic [63:0]             now_i,
   output ntpodmf_pkg::record_type rec_o
);
   import ntpodmf_pkg::*;

   ctl_type     ctl9_ff, ctl10_ff;
   logic [63:0] now9_ff, now10_ff;
   logic [63:0] d41_ff, d32_ff, fwd_ff, rev_ff;
   logic [63:0] delay_in, delay_ff, offset_in, offset_ff;
   logic [63:0] best_delay_in, best_delay_ff;
   logic [63:0] best_offset_in, best_offset_ff;
   logic        have_in, have_ff;
   logic        take;
   logic [63:0] cur_delay, cur_offset;
   logic        cur_have;
   record_type  rec_in, rec_ff;

   always_comb begin
      delay_in  = d41_ff - d32_ff;
      offset_in = (fwd_ff >> 1) + (rev_ff >> 1);
   end

   // only feedback path: the record compare
   always_comb begin
      take       = ctl10_ff.valid && ctl10_ff.ok && (delay_ff < best_delay_ff);
      cur_delay  = take ? delay_ff  : best_delay_ff;
      cur_offset = take ? offset_ff : best_offset_ff;
      cur_have   = take | have_ff;

      rec_in.valid  = ctl10_ff.valid & ctl10_ff.last;
      rec_in.synced = cur_have;
      rec_in.delay  = cur_delay;
      rec_in.offset = cur_offset;
      rec_in.now    = now10_ff;

      if (ctl10_ff.valid && ctl10_ff.last) begin
         best_delay_in  = '1;
         best_offset_in = '0;
         have_in        = 1'b0;
      end else begin
         best_delay_in  = cur_delay;
         best_offset_in = cur_offset;
         have_in        = cur_have;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d41_ff    <= t4_i - t1_i;
         d32_ff    <= t3_i - t2_i;
         fwd_ff    <= t2_i - t1_i;
         rev_ff    <= t3_i - t4_i;
         now9_ff   <= now_i;
         delay_ff  <= delay_in;
         offset_ff <= offset_in;
         now10_ff  <= now9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl9_ff        <= '0;
         ctl10_ff       <= '0;
         best_delay_ff  <= '1;
         best_offset_ff <= '0;
         have_ff        <= 1'b0;
         rec_ff         <= '0;
      end else if (enable) begin
         ctl9_ff        <= ctl_i;
         ctl10_ff       <= ctl9_ff;
         best_delay_ff  <= best_delay_in;
         best_offset_ff <= best_offset_in;
         have_ff        <= have_in;
         rec_ff         <= rec_in;
      end
   end

   assign rec_o = rec_ff;

endmodule

// File: rtl/core/ntpodmf_result.sv
module ntpodmf_result (
   input  logic                    clock,
   input  logic                    reset,
   input  ntpodmf_pkg::record_type rec_i,
   input  logic                    rsp_stall,
   output logic                    hold_o,
   output logic                    rsp_valid,
   output logic                    rsp_synced,
   output logic [63:0]             rsp_unix_us,
   output logic [31:0]             rsp_delay_ms
);
   import ntpodmf_pkg::*;

   logic        hold;
   logic        v12_ff, synced12_ff;
   logic [51:0] sec_prod_in, sec_prod_ff;
   logic [51:0] frac_prod_in, frac_prod_ff;
   logic [41:0] dlo_in, dlo_ff;
   logic [31:0] dhi_in, dhi_ff;
   logic [63:0] now12_ff;
   logic        valid_in, valid_ff;
   logic        synced_ff;
   logic [63:0] epoch_in, epoch_ff;
   logic [31:0] delay_ms_in, delay_ms_ff;

   // freeze the pipeline only when a second result would land on a stalled one
   assign hold = valid_ff & rsp_stall & v12_ff;

   always_comb begin
      sec_prod_in  = 52'(rec_i.offset[63:32]) * 52'(US_PER_S);
      frac_prod_in = 52'(rec_i.offset[31:0]) * 52'(US_PER_S);
      dlo_in       = 42'(rec_i.delay[31:0]) * 42'(MS_PER_S);
      dhi_in       = rec_i.delay[63:32] * 32'(MS_PER_S);
   end

   always_comb begin
      valid_in = v12_ff | (valid_ff & rsp_stall);
      if (synced12_ff) begin
         epoch_in    = 64'(sec_prod_ff) + 64'(frac_prod_ff[51:32]) + now12_ff - SPAN_US;
         delay_ms_in = dhi_ff + 32'(dlo_ff[41:32]);
      end else begin
         epoch_in    = '0;
         delay_ms_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         synced12_ff  <= rec_i.synced;
         sec_prod_ff  <= sec_prod_in;
         frac_prod_ff <= frac_prod_in;
         dlo_ff       <= dlo_in;
         dhi_ff       <= dhi_in;
         now12_ff     <= rec_i.now;
      end
      if (v12_ff && !hold) begin
         synced_ff   <= synced12_ff;
         epoch_ff    <= epoch_in;
         delay_ms_ff <= delay_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (!hold) v12_ff <= rec_i.valid;
         valid_ff <= valid_in;
      end
   end

   assign hold_o       = hold;
   assign rsp_valid    = valid_ff;
   assign rsp_synced   = synced_ff;
   assign rsp_unix_us  = epoch_ff;
   assign rsp_delay_ms = delay_ms_ff;

endmodule

// File: rtl/core/ntp_offset_delay_min_filter_core.sv
// Minimum-delay NTP offset filter.
// Request channel (req_*): one exchange per transfer, accepted when req_valid
// is high and req_stall low. Local times in microseconds are turned into
// 32.32 seconds, delay and offset are formed, and the exchange with the
// smallest delay in the round is kept.
// Response channel (rsp_*): one transfer per round, produced by the request
// flagged req_last_sample; rsp_synced low means no reply was usable and the
// other fields are zero. The record clears after the last request.
// Throughput: one request per cycle while req_stall is low. A request passes
// the input registers, the microsecond to fixed-point conversion, the
// delay, offset and record-compare registers, and the epoch and
// millisecond products before its response reaches the output register.
// Within the min filter the record compare is the only loop; its result is registered back into the record.
// Stall: a waiting response sits in the output register while requests keep
// flowing; req_stall rises only when the next response waits behind the
// stalled one in the output register, and the whole pipeline freezes.
// Reset: synchronous, active high; empties the pipeline and clears the record.
module ntp_offset_delay_min_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_send_time_us,
   input  logic [63:0] req_server_receive_time,
   input  logic [63:0] req_server_transmit_time,
   input  logic [63:0] req_reply_time_us,
   input  logic        req_reply_ok,
   input  logic [63:0] req_current_time_us,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_synced,
   output logic [63:0] rsp_unix_us,
   output logic [31:0] rsp_delay_ms
);
   import ntpodmf_pkg::*;

   logic        hold;
   logic        enable;
   ctl_type     ctl0_in, ctl0_ff;
   logic [63:0] send_ff, recv_ff, xmit_ff, reply_ff, now_ff;
   ctl_type     ctl_ff  [CONV_LAT];
   logic [63:0] recv_d_ff [CONV_LAT];
   logic [63:0] xmit_d_ff [CONV_LAT];
   logic [63:0] now_d_ff  [CONV_LAT];
   logic [63:0] t1, t4;
   record_type  rec;

   assign enable    = ~hold;
   assign req_stall = hold;

   always_comb begin
      ctl0_in.valid = req_valid;
      ctl0_in.ok    = req_reply_ok;
      ctl0_in.last  = req_last_sample;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         send_ff  <= req_send_time_us;
         recv_ff  <= req_server_receive_time;
         xmit_ff  <= req_server_transmit_time;
         reply_ff <= req_reply_time_us;
         now_ff   <= req_current_time_us;
         recv_d_ff[0] <= recv_ff;
         xmit_d_ff[0] <= xmit_ff;
         now_d_ff[0]  <= now_ff;
         for (int i = 1; i < CONV_LAT; i++) begin
            recv_d_ff[i] <= recv_d_ff[i-1];
            xmit_d_ff[i] <= xmit_d_ff[i-1];
            now_d_ff[i]  <= now_d_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
         for (int i = 0; i < CONV_LAT; i++) ctl_ff[i] <= '0;
      end else if (enable) begin
         ctl0_ff   <= ctl0_in;
         ctl_ff[0] <= ctl0_ff;
         for (int i = 1; i < CONV_LAT; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   ntpodmf_us_to_fixed u_conv_send (
      .clock   (clock),
      .enable  (enable),
      .us_i    (send_ff),
      .fixed_o (t1)
   );

   ntpodmf_us_to_fixed u_conv_reply (
      .clock   (clock),
      .enable  (enable),
      .us_i    (reply_ff),
      .fixed_o (t4)
   );

   ntpodmf_min_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .ctl_i  (ctl_ff[CONV_LAT-1]),
      .t1_i   (t1),
      .t2_i   (recv_d_ff[CONV_LAT-1]),
      .t3_i   (xmit_d_ff[CONV_LAT-1]),
      .t4_i   (t4),
      .now_i  (now_d_ff[CONV_LAT-1]),
      .rec_o  (rec)
   );

   ntpodmf_result u_result (
      .clock        (clock),
      .reset        (reset),
      .rec_i        (rec),
      .rsp_stall    (rsp_stall),
      .hold_o       (hold),
      .rsp_valid    (rsp_valid),
      .rsp_synced   (rsp_synced),
      .rsp_unix_us  (rsp_unix_us),
      .rsp_delay_ms (rsp_delay_ms)
   );

endmodule

// File: rtl/core/ntpodmf_checker.sv
module ntpodmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_send_time_us,
   input logic [63:0] req_server_receive_time,
   input logic [63:0] req_server_transmit_time,
   input logic [63:0] req_reply_time_us,
   input logic        req_reply_ok,
   input logic [63:0] req_current_time_us,
   input logic        req_last_sample,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_synced,
   input logic [63:0] rsp_unix_us,
   input logic [31:0] rsp_delay_ms
);

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_synced)
         && $stable(rsp_unix_us) && $stable(rsp_delay_ms))
      else $error("stalled response changed");

   // a round with no usable reply reports zeros
   a_unsynced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_synced |-> rsp_unix_us == 64'd0 && rsp_delay_ms == 32'd0)
      else $error("unsynced response carries nonzero fields");

   // requests are held off only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall present after reset");

endmodule

bind ntp_offset_delay_min_filter_core ntpodmf_checker u_checker (.*);
